@@ src/iaas_pkg.sv @@
// ----------------------------------------------------------------------------
// iaas_pkg
// Shared types, codes and the CRC_A byte step for the Type A anticollision
// and select block.
// ----------------------------------------------------------------------------
`default_nettype none

package iaas_pkg;

  localparam int unsigned MAX_CASCADE_LEVELS = 3;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_BYTE  = 2'd1;
  localparam logic [1:0] OP_END   = 2'd2;

  localparam logic [1:0] RX_OK        = 2'd0;
  localparam logic [1:0] RX_COLLISION = 2'd1;
  localparam logic [1:0] RX_TIMEOUT   = 2'd2;
  localparam logic [1:0] RX_LINK_ERR  = 2'd3;

  localparam logic [1:0] KIND_FRAME  = 2'd0;
  localparam logic [1:0] KIND_UID    = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_TIMEOUT     = 3'd1;
  localparam logic [2:0] ST_LINK_ERR    = 3'd2;
  localparam logic [2:0] ST_UNRESOLVED  = 3'd3;
  localparam logic [2:0] ST_NO_PROGRESS = 3'd4;
  localparam logic [2:0] ST_BAD_SAK     = 3'd5;
  localparam logic [2:0] ST_CRC_ERR     = 3'd6;

  localparam logic [7:0]  SEL_CL1     = 8'h93;
  localparam logic [7:0]  CASCADE_TAG = 8'h88;
  localparam logic [7:0]  NVB_SELECT  = 8'h70;
  localparam logic [7:0]  SAK_CASCADE = 8'h04;
  localparam logic [15:0] CRC_INIT    = 16'h6363;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EMIT,
    S_SEL_CRC,
    S_SEL_STORE,
    S_SAK_CRC,
    S_SAK_CHK,
    S_UID,
    S_FIN
  } state_e;

  typedef struct packed {
    logic       init;
    logic       en;
    logic [7:0] data;
  } crc_ctl_t;

  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [7:0] ch;
    ch = b ^ crc[7:0];
    ch = ch ^ {ch[3:0], 4'h0};
    return {8'h00, crc[15:8]} ^ {ch, 8'h00} ^ {5'h00, ch, 3'h0} ^ {12'h000, ch[7:4]};
  endfunction

endpackage

`default_nettype wire

@@ src/iso14443a_anticollision_select.sv @@
// ----------------------------------------------------------------------------
// iso14443a_anticollision_select
// Reader-side Type A cascade anticollision and select sequencer.
// ----------------------------------------------------------------------------
// An item is taken only while the block is idle. Response bytes and ignored
// items leave it idle; a status item that ends the run passes S_FIN for the
// status result. Every result goes through the output register, held while
// out_stall_i is high. A frame has 2 to 9 bytes; a SELECT frame first walks
// seven bytes through the byte-serial CRC_A unit, and a SAK check uses the
// same unit. The final UID run sends up to 10 UID bytes. in_stall_o is high
// while the sequencer works on an item.
`default_nettype none

module iso14443a_anticollision_select (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [1:0] op_i,
  input  wire logic [7:0] rx_byte_i,
  input  wire logic [1:0] rx_status_i,
  input  wire logic       coll_pos_valid_i,
  input  wire logic [4:0] coll_pos_i,
  input  wire logic [2:0] rx_last_bits_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [1:0]      kind_o,
  output logic [7:0]      byte_value_o,
  output logic [2:0]      tx_last_bits_o,
  output logic            last_o,
  output logic [2:0]      status_o,
  output logic [7:0]      sak_o,
  output logic [3:0]      uid_length_o
);

  iaas_pkg::state_e state_q, state_d;
  logic [1:0] level_q, level_d;
  logic [5:0] kb_q, kb_d;
  logic       insel_q, insel_d;
  logic [3:0] rxc_q, rxc_d;
  logic       busy_q, busy_d;
  logic [3:0] cnt_q, cnt_d;
  logic [2:0] fst_q, fst_d;
  logic [7:0] frame_q [9];
  logic [7:0] frame_d [9];
  logic [7:0] uid_q [10];
  logic [7:0] uid_d [10];

  logic       ov_q, ov_d;
  logic [1:0] okind_q, okind_d;
  logic [7:0] obyte_q, obyte_d;
  logic [2:0] otxl_q, otxl_d;
  logic       olast_q, olast_d;
  logic [2:0] ost_q, ost_d;
  logic [7:0] osak_q, osak_d;
  logic [3:0] olen_q, olen_d;

  iaas_pkg::crc_ctl_t crc_ctl;
  logic [15:0] crc;

  iaas_crc u_crc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (crc_ctl),
    .crc_o  (crc)
  );

  logic       accept, out_free;
  logic [3:0] base, cap, widx, used, ulen;
  logic [2:0] txl, al;
  logic [5:0] pos;
  logic [3:0] cidx;
  logic [7:0] mask, bcc, emit_byte;
  logic [3:0] uidx;

  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !ov_q || !out_stall_i;
  assign in_stall_o = (state_q != iaas_pkg::S_IDLE);

  always_comb begin
    base = insel_q ? 4'd6 : 4'd2 + {2'b00, kb_q[4:3]};
    cap  = 4'd9 - base;
    widx = base + rxc_q;
    al   = kb_q[2:0];
    mask = 8'((9'd1 << al) - 9'd1);
    pos  = (coll_pos_i == 5'd0) ? 6'd32 : {1'b0, coll_pos_i};
    cidx = 4'd1 + {1'b0, pos[5:3]} + {3'b000, (pos[2:0] != 3'd0)};
    txl  = insel_q ? 3'd0 : kb_q[2:0];
    used = insel_q ? 4'd9 : 4'd2 + {2'b00, kb_q[4:3]} + {3'b000, (kb_q[2:0] != 3'd0)};
    ulen = 4'd3 * {2'b00, level_q} + 4'd1;
    bcc  = frame_q[2] ^ frame_q[3] ^ frame_q[4] ^ frame_q[5];
    uidx = 4'd3 * ({2'b00, level_q} - 4'd1);
    if (cnt_q == 4'd1) begin
      emit_byte = insel_q ? iaas_pkg::NVB_SELECT
                          : {1'b0, 3'(3'd2 + {1'b0, kb_q[4:3]}), 1'b0, txl};
    end else begin
      emit_byte = frame_q[cnt_q];
    end
  end

  always_comb begin
    state_d = state_q;
    level_d = level_q;
    kb_d    = kb_q;
    insel_d = insel_q;
    rxc_d   = rxc_q;
    busy_d  = busy_q;
    cnt_d   = cnt_q;
    fst_d   = fst_q;
    frame_d = frame_q;
    uid_d   = uid_q;
    ov_d    = ov_q && out_stall_i;
    okind_d = okind_q;
    obyte_d = obyte_q;
    otxl_d  = otxl_q;
    olast_d = olast_q;
    ost_d   = ost_q;
    osak_d  = osak_q;
    olen_d  = olen_q;
    crc_ctl = '0;

    unique case (state_q)
      iaas_pkg::S_IDLE: begin
        if (accept) begin
          if (op_i == iaas_pkg::OP_START) begin
            level_d = 2'd1;
            for (int i = 0; i < 10; i++) uid_d[i] = 8'h00;
            for (int i = 0; i < 9; i++) frame_d[i] = 8'h00;
            frame_d[0] = iaas_pkg::SEL_CL1;
            kb_d    = 6'd0;
            insel_d = 1'b0;
            busy_d  = 1'b1;
            cnt_d   = 4'd0;
            state_d = iaas_pkg::S_EMIT;
          end else if (busy_q && op_i == iaas_pkg::OP_BYTE) begin
            if (rxc_q < cap) begin
              if (rxc_q == 4'd0 && !insel_q && al != 3'd0) begin
                frame_d[widx] = (frame_q[widx] & mask) | (rx_byte_i & ~mask);
              end else begin
                frame_d[widx] = rx_byte_i;
              end
            end
            if (rxc_q != 4'd15) rxc_d = rxc_q + 4'd1;
          end else if (busy_q && op_i == iaas_pkg::OP_END) begin
            state_d = iaas_pkg::S_FIN;
            if (rx_status_i == iaas_pkg::RX_TIMEOUT) begin
              fst_d = iaas_pkg::ST_TIMEOUT;
            end else if (rx_status_i == iaas_pkg::RX_LINK_ERR || rxc_q > cap) begin
              fst_d = iaas_pkg::ST_LINK_ERR;
            end else if (rx_status_i == iaas_pkg::RX_COLLISION) begin
              if (!coll_pos_valid_i) begin
                fst_d = iaas_pkg::ST_UNRESOLVED;
              end else if (pos <= kb_q) begin
                fst_d = iaas_pkg::ST_NO_PROGRESS;
              end else begin
                kb_d = pos;
                frame_d[cidx] = frame_q[cidx] | (8'h01 << ((pos[2:0] - 3'd1)));
                cnt_d = 4'd0;
                if (pos[5]) begin
                  insel_d = 1'b1;
                  state_d = iaas_pkg::S_SEL_CRC;
                end else begin
                  state_d = iaas_pkg::S_EMIT;
                end
              end
            end else if (!insel_q) begin
              kb_d    = 6'd32;
              insel_d = 1'b1;
              cnt_d   = 4'd0;
              state_d = iaas_pkg::S_SEL_CRC;
            end else begin
              // SAK answer: the level's UID bytes are kept before any check.
              if (frame_q[2] == iaas_pkg::CASCADE_TAG) begin
                for (int i = 0; i < 3; i++) uid_d[uidx + 4'(i)] = frame_q[3 + i];
              end else begin
                for (int i = 0; i < 4; i++) begin
                  if (uidx + 4'(i) < 4'd10) uid_d[uidx + 4'(i)] = frame_q[2 + i];
                end
              end
              if (rxc_q != 4'd3 || rx_last_bits_i != 3'd0) begin
                fst_d = iaas_pkg::ST_BAD_SAK;
              end else begin
                state_d = iaas_pkg::S_SAK_CRC;
              end
            end
          end
        end
      end

      iaas_pkg::S_EMIT: begin
        if (out_free) begin
          ov_d    = 1'b1;
          okind_d = iaas_pkg::KIND_FRAME;
          obyte_d = emit_byte;
          otxl_d  = txl;
          olast_d = (cnt_q == used - 4'd1);
          ost_d   = iaas_pkg::ST_OK;
          osak_d  = 8'h00;
          olen_d  = 4'd0;
          cnt_d   = cnt_q + 4'd1;
          if (cnt_q == used - 4'd1) begin
            rxc_d   = 4'd0;
            cnt_d   = 4'd0;
            state_d = iaas_pkg::S_IDLE;
          end
        end
      end

      iaas_pkg::S_SEL_CRC: begin
        crc_ctl.init = (cnt_q == 4'd0);
        crc_ctl.en   = 1'b1;
        if (cnt_q == 4'd1) begin
          crc_ctl.data = iaas_pkg::NVB_SELECT;
        end else if (cnt_q == 4'd6) begin
          crc_ctl.data = bcc;
          frame_d[6]   = bcc;
        end else begin
          crc_ctl.data = frame_q[cnt_q];
        end
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == 4'd6) state_d = iaas_pkg::S_SEL_STORE;
      end

      iaas_pkg::S_SEL_STORE: begin
        frame_d[7] = crc[7:0];
        frame_d[8] = crc[15:8];
        cnt_d   = 4'd0;
        state_d = iaas_pkg::S_EMIT;
      end

      iaas_pkg::S_SAK_CRC: begin
        crc_ctl.init = 1'b1;
        crc_ctl.data = frame_q[6];
        state_d = iaas_pkg::S_SAK_CHK;
      end

      iaas_pkg::S_SAK_CHK: begin
        cnt_d = 4'd0;
        if (frame_q[7] != crc[7:0] || frame_q[8] != crc[15:8]) begin
          fst_d   = iaas_pkg::ST_CRC_ERR;
          state_d = iaas_pkg::S_FIN;
        end else if ((frame_q[6] & iaas_pkg::SAK_CASCADE) != 8'h00) begin
          if (32'(level_q) >= iaas_pkg::MAX_CASCADE_LEVELS || level_q == 2'd3) begin
            fst_d   = iaas_pkg::ST_BAD_SAK;
            state_d = iaas_pkg::S_FIN;
          end else begin
            level_d = level_q + 2'd1;
            for (int i = 0; i < 9; i++) frame_d[i] = 8'h00;
            frame_d[0] = iaas_pkg::SEL_CL1 + {5'd0, level_q, 1'b0};
            kb_d    = 6'd0;
            insel_d = 1'b0;
            state_d = iaas_pkg::S_EMIT;
          end
        end else begin
          fst_d   = iaas_pkg::ST_OK;
          state_d = iaas_pkg::S_UID;
        end
      end

      iaas_pkg::S_UID: begin
        if (out_free) begin
          ov_d    = 1'b1;
          okind_d = iaas_pkg::KIND_UID;
          obyte_d = uid_q[cnt_q];
          otxl_d  = 3'd0;
          olast_d = 1'b0;
          ost_d   = iaas_pkg::ST_OK;
          osak_d  = 8'h00;
          olen_d  = 4'd0;
          cnt_d   = cnt_q + 4'd1;
          if (cnt_q == ulen - 4'd1) state_d = iaas_pkg::S_FIN;
        end
      end

      iaas_pkg::S_FIN: begin
        if (out_free) begin
          ov_d    = 1'b1;
          okind_d = iaas_pkg::KIND_STATUS;
          obyte_d = 8'h00;
          otxl_d  = 3'd0;
          olast_d = 1'b1;
          ost_d   = fst_q;
          osak_d  = (fst_q == iaas_pkg::ST_OK) ? frame_q[6] : 8'h00;
          olen_d  = (fst_q == iaas_pkg::ST_OK) ? ulen : 4'd0;
          busy_d  = 1'b0;
          cnt_d   = 4'd0;
          state_d = iaas_pkg::S_IDLE;
        end
      end

      default: state_d = iaas_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= iaas_pkg::S_IDLE;
      level_q <= 2'd1;
      kb_q    <= 6'd0;
      insel_q <= 1'b0;
      rxc_q   <= 4'd0;
      busy_q  <= 1'b0;
      cnt_q   <= 4'd0;
      fst_q   <= iaas_pkg::ST_OK;
      ov_q    <= 1'b0;
      for (int i = 0; i < 9; i++) frame_q[i] <= 8'h00;
    end else begin
      state_q <= state_d;
      level_q <= level_d;
      kb_q    <= kb_d;
      insel_q <= insel_d;
      rxc_q   <= rxc_d;
      busy_q  <= busy_d;
      cnt_q   <= cnt_d;
      fst_q   <= fst_d;
      ov_q    <= ov_d;
      frame_q <= frame_d;
    end
  end

  always_ff @(posedge clk_i) begin
    uid_q   <= uid_d;
    okind_q <= okind_d;
    obyte_q <= obyte_d;
    otxl_q  <= otxl_d;
    olast_q <= olast_d;
    ost_q   <= ost_d;
    osak_q  <= osak_d;
    olen_q  <= olen_d;
  end

  assign out_valid_o    = ov_q;
  assign kind_o         = okind_q;
  assign byte_value_o   = obyte_q;
  assign tx_last_bits_o = otxl_q;
  assign last_o         = olast_q;
  assign status_o       = ost_q;
  assign sak_o          = osak_q;
  assign uid_length_o   = olen_q;

  // A status transfer always closes the run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && okind_q == iaas_pkg::KIND_STATUS) |-> olast_q)
    else $error("status item without last");

  // The sequencer only leaves idle with a run open.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != iaas_pkg::S_IDLE) |-> busy_q)
    else $error("sequencer active without a run");

  // A SELECT frame always has all bits of the level known.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    insel_q |-> (kb_q == 6'd32))
    else $error("select phase without full UID bits");

  // The CRC walk over the SELECT frame never runs past its seven bytes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == iaas_pkg::S_SEL_CRC) |-> (cnt_q <= 4'd6))
    else $error("CRC walk overrun");

endmodule

`default_nettype wire

@@ src/iaas_crc.sv @@
// ----------------------------------------------------------------------------
// iaas_crc
// Byte-serial CRC_A register, shared by the SELECT frame build and the
// SAK check.
// ----------------------------------------------------------------------------
`default_nettype none

module iaas_crc (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  iaas_pkg::crc_ctl_t     ctl_i,
  output logic [15:0]            crc_o
);

  logic [15:0] crc_q, crc_d;

  always_comb begin
    crc_d = crc_q;
    if (ctl_i.init) begin
      crc_d = iaas_pkg::crc_step(iaas_pkg::CRC_INIT, ctl_i.data);
    end else if (ctl_i.en) begin
      crc_d = iaas_pkg::crc_step(crc_q, ctl_i.data);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) crc_q <= iaas_pkg::CRC_INIT;
    else         crc_q <= crc_d;
  end

  assign crc_o = crc_q;

endmodule

`default_nettype wire

@@ sim/iso14443a_anticollision_select_test.sv @@
// ----------------------------------------------------------------------------
// iso14443a_anticollision_select_test
// Drives directed and random card dialogues into the Type A anticollision and
// select sequencer. A scoreboard predicts every transmit byte, UID byte and
// status item, and compares them in order with what the block sends out.
// ----------------------------------------------------------------------------
`default_nettype none

module iso14443a_anticollision_select_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int unsigned IDLE_LIMIT = 5000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned RANDOM_ITEMS = 310;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
    logic [2:0] txl;
    logic       last;
    logic [2:0] status;
    logic [7:0] sak;
    logic [3:0] len;
  } result_t;

  class select_scoreboard;
    result_t    pending[$];
    int         errors;
    int         checked;
    int         runs_ok;
    int         counted;
    logic [1:0] level;
    int         kb;
    bit         in_sel;
    logic [7:0] fs[9];
    int         rxc;
    logic [7:0] uid[10];
    bit         busy;

    function new();
      level = 1;
      kb = 0;
      in_sel = 0;
      foreach (fs[i]) fs[i] = 8'h00;
      foreach (uid[i]) uid[i] = 8'h00;
      rxc = 0;
      busy = 0;
    endfunction

    function logic [15:0] crc_a(input int first, input int n);
      logic [15:0] c;
      logic [7:0]  ch;
      c = 16'h6363;
      for (int i = first; i < first + n; i++) begin
        ch = fs[i] ^ c[7:0];
        ch = ch ^ (ch << 4);
        c = (c >> 8) ^ ({8'h00, ch} << 8) ^ ({8'h00, ch} << 3) ^ ({8'h00, ch} >> 4);
      end
      return c;
    endfunction

    function void push(logic [1:0] k, logic [7:0] v, logic [2:0] t, logic l,
                       logic [2:0] s, logic [7:0] sk, logic [3:0] n);
      pending.push_back('{k, v, t, l, s, sk, n});
    endfunction

    function void open_level();
      foreach (fs[i]) fs[i] = 8'h00;
      fs[0] = 8'h93 + 8'(2 * (level - 1));
      kb = 0;
      in_sel = 0;
    endfunction

    function void send_frame();
      int          used;
      int          whole;
      logic [2:0]  txl;
      logic [15:0] c;
      if (in_sel) begin
        fs[1] = iaas_pkg::NVB_SELECT;
        fs[6] = fs[2] ^ fs[3] ^ fs[4] ^ fs[5];
        c = crc_a(0, 7);
        fs[7] = c[7:0];
        fs[8] = c[15:8];
        txl = 3'd0;
        used = 9;
      end else begin
        whole = (kb & 31) >> 3;
        txl = 3'(kb & 7);
        fs[1] = 8'(((2 + whole) << 4) | txl);
        used = 2 + whole + (txl != 0 ? 1 : 0);
      end
      rxc = 0;
      for (int i = 0; i < used; i++)
        push(iaas_pkg::KIND_FRAME, fs[i], txl, i + 1 == used, iaas_pkg::ST_OK,
             8'h00, 4'd0);
    endfunction

    function void end_run(logic [2:0] st);
      push(iaas_pkg::KIND_STATUS, 8'h00, 3'd0, 1'b1, st, 8'h00, 4'd0);
      busy = 0;
    endfunction

    // Returns 1 when the transfer is not simply ignored by the block.
    function bit note_input(logic [1:0] op, logic [7:0] b, logic [1:0] rs, logic pv,
                            logic [4:0] cp, logic [2:0] rl);
      int         base;
      int         cap;
      int         pos;
      int         idx;
      int         uidx;
      int         src;
      int         n;
      int         len;
      logic [7:0] m;
      logic [15:0] c;
      if (op == iaas_pkg::OP_START) begin
        level = 1;
        foreach (uid[i]) uid[i] = 8'h00;
        busy = 1;
        open_level();
        send_frame();
        return 1;
      end
      if (op == OP_UNUSED || !busy) return 0;
      base = in_sel ? 6 : 2 + ((kb & 31) >> 3);
      cap = 9 - base;
      if (op == iaas_pkg::OP_BYTE) begin
        if (rxc < cap) begin
          idx = base + rxc;
          if (rxc == 0 && !in_sel && (kb & 7) != 0) begin
            m = 8'((1 << (kb & 7)) - 1);
            fs[idx] = (fs[idx] & m) | (b & ~m);
          end else begin
            fs[idx] = b;
          end
        end
        if (rxc < 15) rxc++;
        return 1;
      end
      if (rs == iaas_pkg::RX_TIMEOUT) begin
        end_run(iaas_pkg::ST_TIMEOUT);
        return 1;
      end
      if (rs == iaas_pkg::RX_LINK_ERR || rxc > cap) begin
        end_run(iaas_pkg::ST_LINK_ERR);
        return 1;
      end
      if (rs == iaas_pkg::RX_COLLISION) begin
        if (!pv) begin
          end_run(iaas_pkg::ST_UNRESOLVED);
          return 1;
        end
        pos = (cp == 0) ? 32 : int'(cp);
        if (pos <= kb) begin
          end_run(iaas_pkg::ST_NO_PROGRESS);
          return 1;
        end
        kb = pos;
        idx = 1 + (pos >> 3) + ((pos & 7) != 0 ? 1 : 0);
        fs[idx] = fs[idx] | 8'(1 << ((pos - 1) & 7));
        if (kb >= 32) in_sel = 1;
        send_frame();
        return 1;
      end
      if (!in_sel) begin
        kb = 32;
        in_sel = 1;
        send_frame();
        return 1;
      end
      // SAK answer to a SELECT frame.
      uidx = 3 * (level - 1);
      src = (fs[2] == iaas_pkg::CASCADE_TAG) ? 3 : 2;
      n = (fs[2] == iaas_pkg::CASCADE_TAG) ? 3 : 4;
      for (int i = 0; i < n; i++)
        if (uidx + i < 10) uid[uidx + i] = fs[src + i];
      if (rxc != 3 || rl != 0) begin
        end_run(iaas_pkg::ST_BAD_SAK);
        return 1;
      end
      c = crc_a(6, 1);
      if (fs[7] != c[7:0] || fs[8] != c[15:8]) begin
        end_run(iaas_pkg::ST_CRC_ERR);
        return 1;
      end
      if ((fs[6] & iaas_pkg::SAK_CASCADE) != 0) begin
        if (level >= iaas_pkg::MAX_CASCADE_LEVELS) begin
          end_run(iaas_pkg::ST_BAD_SAK);
          return 1;
        end
        level++;
        open_level();
        send_frame();
        return 1;
      end
      len = 3 * level + 1;
      for (int i = 0; i < len && i < 10; i++)
        push(iaas_pkg::KIND_UID, uid[i], 3'd0, 1'b0, iaas_pkg::ST_OK, 8'h00, 4'd0);
      push(iaas_pkg::KIND_STATUS, 8'h00, 3'd0, 1'b1, iaas_pkg::ST_OK, fs[6], 4'(len));
      busy = 0;
      runs_ok++;
      return 1;
    endfunction

    function void report(string what, result_t got, result_t want);
      errors++;
      $display("ERROR %s: got %h expected %h", what, got, want);
    endfunction

    function void check_result(result_t got);
      result_t want;
      checked++;
      if (pending.size() == 0) begin
        report("unexpected result", got, '0);
        return;
      end
      want = pending.pop_front();
      if (got.kind != want.kind) report("kind", got, want);
      if (got.value != want.value) report("byte_value", got, want);
      if (got.txl != want.txl) report("tx_last_bits", got, want);
      if (got.last != want.last) report("last", got, want);
      if (got.status != want.status) report("status", got, want);
      if (got.sak != want.sak) report("sak", got, want);
      if (got.len != want.len) report("uid_length", got, want);
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid;
  logic       in_stall;
  logic [1:0] op;
  logic [7:0] rx_byte;
  logic [1:0] rx_status;
  logic       coll_pos_valid;
  logic [4:0] coll_pos;
  logic [2:0] rx_last_bits;
  logic       out_valid;
  logic       out_stall;
  result_t    res;

  select_scoreboard sb;
  bit  hold_req;
  bit  hold_done;
  int  burst_left;
  int  idle_cycles;

  iso14443a_anticollision_select dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .op_i             (op),
    .rx_byte_i        (rx_byte),
    .rx_status_i      (rx_status),
    .coll_pos_valid_i (coll_pos_valid),
    .coll_pos_i       (coll_pos),
    .rx_last_bits_i   (rx_last_bits),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .kind_o           (res.kind),
    .byte_value_o     (res.value),
    .tx_last_bits_o   (res.txl),
    .last_o           (res.last),
    .status_o         (res.status),
    .sak_o            (res.sak),
    .uid_length_o     (res.len)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) sb.check_result(res);
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (rst_ni) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout after %0d cycles without a transfer", IDLE_LIMIT);
        $display("iso14443a_anticollision_select: mismatch");
        $finish;
      end
    end
  end

  // Receiver stall: phases of no stall, light stall and heavy stall, plus one
  // long hold-off on request so that the block backs up onto its input.
  initial begin : receiver
    int mode;
    out_stall = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 0;
      end
      mode = $urandom_range(0, 2);
      repeat ($urandom_range(10, 60)) begin
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
        @(posedge clk_i);
      end
    end
  end

  task automatic send(logic [1:0] o, logic [7:0] b, logic [1:0] rs, logic pv,
                      logic [4:0] cp, logic [2:0] rl);
    in_valid <= 1'b1;
    op <= o;
    rx_byte <= b;
    rx_status <= rs;
    coll_pos_valid <= pv;
    coll_pos <= cp;
    rx_last_bits <= rl;
    do @(posedge clk_i); while (in_stall);
    if (sb.note_input(o, b, rs, pv, cp, rl)) sb.counted++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = $urandom_range(0, 12);
    end
  endtask

  task automatic card_bytes(int n, bit tag_first);
    for (int i = 0; i < n; i++)
      send(iaas_pkg::OP_BYTE, (i == 0 && tag_first) ? iaas_pkg::CASCADE_TAG : 8'($urandom),
           2'($urandom), 1'($urandom), 5'($urandom), 3'($urandom));
  endtask

  task automatic sak_answer(logic [7:0] sak, bit corrupt, int extra);
    logic [15:0] c;
    logic [7:0]  ch;
    ch = sak ^ 8'h63;
    ch = ch ^ (ch << 4);
    c = 16'h0063 ^ ({8'h00, ch} << 8) ^ ({8'h00, ch} << 3) ^ ({8'h00, ch} >> 4);
    send(iaas_pkg::OP_BYTE, sak, 2'($urandom), 1'($urandom), 5'($urandom), 3'($urandom));
    send(iaas_pkg::OP_BYTE, c[7:0] ^ (corrupt ? 8'(1 << $urandom_range(0, 7)) : 8'h00),
         2'($urandom), 1'($urandom), 5'($urandom), 3'($urandom));
    send(iaas_pkg::OP_BYTE, c[15:8], 2'($urandom), 1'($urandom), 5'($urandom),
         3'($urandom));
    card_bytes(extra, 0);
  endtask

  // One dialogue from start to its end, mostly well formed.
  task automatic card_run();
    int         pos;
    logic [7:0] sak;
    send(iaas_pkg::OP_START, 8'($urandom), 2'($urandom), 1'($urandom), 5'($urandom),
         3'($urandom));
    while (sb.busy) begin
      if (!sb.in_sel) begin
        card_bytes(5 - (sb.kb >> 3) + ($urandom_range(0, 30) == 0 ? 5 : 0),
                   sb.kb == 0 && $urandom_range(0, 2) == 0);
        if ($urandom_range(0, 9) < 4) begin
          pos = $urandom_range(sb.kb + 1, 32);
          if ($urandom_range(0, 15) == 0) pos = $urandom_range(1, 32);
          send(iaas_pkg::OP_END, 8'($urandom), iaas_pkg::RX_COLLISION,
               $urandom_range(0, 15) != 0, 5'(pos), 3'($urandom));
        end else begin
          send(iaas_pkg::OP_END, 8'($urandom),
               ($urandom_range(0, 19) == 0) ? 2'($urandom) : iaas_pkg::RX_OK,
               1'($urandom), 5'($urandom), 3'($urandom));
        end
      end else begin
        sak = 8'($urandom);
        if (sb.level == iaas_pkg::MAX_CASCADE_LEVELS && $urandom_range(0, 3) != 0)
          sak[2] = 1'b0;
        sak_answer(sak, $urandom_range(0, 9) == 0, ($urandom_range(0, 15) == 0) ? 1 : 0);
        send(iaas_pkg::OP_END, 8'($urandom),
             ($urandom_range(0, 19) == 0) ? 2'($urandom) : iaas_pkg::RX_OK,
             1'($urandom), 5'($urandom),
             ($urandom_range(0, 15) == 0) ? 3'($urandom) : 3'd0);
      end
      // A dialogue may be cut short by a fresh start.
      if (sb.busy && $urandom_range(0, 40) == 0) return;
    end
  endtask

  initial begin
    sb = new();
    hold_req = 0;
    hold_done = 0;
    burst_left = 0;
    idle_cycles = 0;
    rst_ni = 1'b0;
    in_valid = 1'b0;
    op = iaas_pkg::OP_START;
    rx_byte = 8'h00;
    rx_status = iaas_pkg::RX_OK;
    coll_pos_valid = 1'b0;
    coll_pos = 5'd0;
    rx_last_bits = 3'd0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: ignored items, the unresolved, timeout, link error and no-progress
    // endings, a partial byte, and a cascade-tag level whose SAK opens level two.
    send(iaas_pkg::OP_BYTE, 8'hFF, iaas_pkg::RX_OK, 1'b1, 5'h1F, 3'h7);
    send(iaas_pkg::OP_END, 8'h00, iaas_pkg::RX_OK, 1'b0, 5'h00, 3'h0);
    send(OP_UNUSED, 8'hFF, iaas_pkg::RX_LINK_ERR, 1'b1, 5'h1F, 3'h7);
    send(iaas_pkg::OP_START, 8'h00, iaas_pkg::RX_OK, 1'b0, 5'h00, 3'h0);
    send(iaas_pkg::OP_END, 8'h00, iaas_pkg::RX_COLLISION, 1'b0, 5'h05, 3'h0);
    send(iaas_pkg::OP_START, 8'h00, iaas_pkg::RX_OK, 1'b0, 5'h00, 3'h0);
    send(iaas_pkg::OP_END, 8'h00, iaas_pkg::RX_TIMEOUT, 1'b0, 5'h00, 3'h0);
    send(iaas_pkg::OP_START, 8'h00, iaas_pkg::RX_OK, 1'b0, 5'h00, 3'h0);
    send(iaas_pkg::OP_START, 8'h00, iaas_pkg::RX_OK, 1'b0, 5'h00, 3'h0);
    send(iaas_pkg::OP_END, 8'h00, iaas_pkg::RX_LINK_ERR, 1'b0, 5'h00, 3'h0);
    send(iaas_pkg::OP_START, 8'h00, iaas_pkg::RX_OK, 1'b0, 5'h00, 3'h0);
    send(iaas_pkg::OP_BYTE, iaas_pkg::CASCADE_TAG, iaas_pkg::RX_OK, 1'b0, 5'h00, 3'h0);
    send(iaas_pkg::OP_END, 8'h00, iaas_pkg::RX_COLLISION, 1'b1, 5'd5, 3'd5);
    send(iaas_pkg::OP_BYTE, 8'hFF, iaas_pkg::RX_OK, 1'b0, 5'h00, 3'h0);
    card_bytes(4, 0);
    send(iaas_pkg::OP_END, 8'h00, iaas_pkg::RX_COLLISION, 1'b1, 5'd3, 3'h0);
    send(iaas_pkg::OP_START, 8'h00, iaas_pkg::RX_OK, 1'b0, 5'h00, 3'h0);
    card_bytes(5, 1);
    send(iaas_pkg::OP_END, 8'h00, iaas_pkg::RX_COLLISION, 1'b1, 5'd0, 3'h0);
    sak_answer(iaas_pkg::SAK_CASCADE, 0, 0);
    send(iaas_pkg::OP_END, 8'h00, iaas_pkg::RX_OK, 1'b0, 5'h00, 3'h0);

    sb.counted = 0;
    while (sb.counted < RANDOM_ITEMS) begin
      if (!hold_done && sb.counted > RANDOM_ITEMS / 2) begin
        hold_req = 1;
        hold_done = 1;
      end
      if ($urandom_range(0, 9) < 8) begin
        card_run();
      end else begin
        repeat ($urandom_range(1, 4))
          send(2'($urandom), 8'($urandom), 2'($urandom), 1'($urandom),
               5'($urandom), 3'($urandom));
      end
    end
    in_valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("Checked %0d results; %0d selections ran to a full UID.",
             sb.checked, sb.runs_ok);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("iso14443a_anticollision_select: match");
    end else begin
      $display("iso14443a_anticollision_select: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire
